[rtl/mtu_pkg.sv]
// shared constants, types and codes of the multi timer unit
// no dependencies; used by the interfaces, the step unit, the top level and the checker
package mtu_pkg;

   localparam int NUM_TIMERS     = 4;
   localparam int PRESCALE_BITS  = 16;
   localparam int TIMER_IDX_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int IRQ_BITS       = 4;
   localparam int IRQ_SHOWN      = (NUM_TIMERS < IRQ_BITS) ? NUM_TIMERS : IRQ_BITS;
   localparam int CTL_BITS       = 6;

   // control bit positions
   localparam int CTL_EN = 0;
   localparam int CTL_RS = 1;
   localparam int CTL_LD = 2;
   localparam int CTL_IE = 3;
   localparam int CTL_IP = 4;
   localparam int CTL_CH = 5;

   // request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // register offsets inside a 16-byte block
   localparam logic [3:0] OFS_COUNT  = 4'h0;
   localparam logic [3:0] OFS_RELOAD = 4'h4;
   localparam logic [3:0] OFS_CTRL   = 4'h8;
   localparam logic [3:0] OFS_LATCH  = 4'hC;
   localparam logic [3:0] BLK_CORE   = 4'h0;

   typedef logic [CTL_BITS-1:0]       ctl_type;
   typedef logic [TIMER_IDX_BITS-1:0] tidx_type;

   // one timer's word in the timer memory
   typedef struct packed {
      logic [31:0] count;
      logic [31:0] reload;
      logic [31:0] latch;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      ctl_type   ctl;
      logic      prev_mark;
      logic      first;
   } step_arg_type;

   typedef struct packed {
      entry_type entry;
      ctl_type   ctl;
      logic      set_mark;
      logic      clear_prev_mark;
   } step_res_type;

endpackage

[rtl/mtu_ifs.sv]
// valid/ready channel interfaces of the multi timer unit
// depends on mtu_pkg for the irq width
interface mtu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  bus_address;
   logic [31:0] write_data;

   modport source (output valid, req_type, bus_address, write_data, input ready);
   modport sink   (input valid, req_type, bus_address, write_data, output ready);
endinterface

interface mtu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [31:0]                  read_data;
   logic [mtu_pkg::IRQ_BITS-1:0] irq_pending;

   modport source (output valid, read_data, irq_pending, input ready);
   modport sink   (input valid, read_data, irq_pending, output ready);
endinterface

[rtl/multi_timer_unit_with_prescaler.sv]
// Timer unit with a shared prescaler and a bank of 32-bit down-counters.
// req_chan takes one word per item: a prescaler tick, a bus read or a bus
// write (byte address, core block at 0x00, timer n at 0x10*(n+1)).
// rsp_chan returns one word per item: the read data (zero for ticks and
// writes) and the interrupt-pending bits of timers 0..3 after the item.
// Items are handled one at a time. Path from accept to the output register:
//   tick without prescaler underflow: straight to the done state
//   bus read or write: the bus state (a timer memory read and, for writes, a write back)
//   tick with prescaler underflow: the step state, one timer per cycle through
//     the single step unit and the timer memory's read and write ports, then done
// req_chan is ready again in the cycle the result enters the output register,
// so a new word is taken while an earlier result still waits on rsp_chan.
// If rsp_chan stalls, a finished result waits in the block until the output
// register frees up. Reset (synchronous) clears the prescaler, all control
// bits and underflow marks, and the timer memory reads as zero until written.
// Depends on mtu_pkg, mtu_ifs and mtu_step.
module multi_timer_unit_with_prescaler (
   input logic              clock,
   input logic              reset,
   mtu_req_if.sink          req_chan,
   mtu_rsp_if.source        rsp_chan
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BUS  = 2'd1;
   localparam logic [1:0] S_STEP = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam mtu_pkg::tidx_type LAST_TIMER =
      mtu_pkg::TIMER_IDX_BITS'(mtu_pkg::NUM_TIMERS - 1);
   localparam logic [3:0] NUM_BLKS = 4'(mtu_pkg::NUM_TIMERS);

   // control state
   logic [1:0]                         state_ff, state_in;
   logic [mtu_pkg::PRESCALE_BITS-1:0]  presc_cnt_ff, presc_cnt_in;
   logic [mtu_pkg::PRESCALE_BITS-1:0]  presc_rld_ff, presc_rld_in;
   mtu_pkg::ctl_type                   ctl_ff [mtu_pkg::NUM_TIMERS];
   mtu_pkg::ctl_type                   ctl_in [mtu_pkg::NUM_TIMERS];
   logic [mtu_pkg::NUM_TIMERS-1:0]     mark_ff, mark_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [1:0]                         op_ff, op_in;
   logic [7:0]                         addr_ff, addr_in;
   logic [31:0]                        data_ff, data_in;
   mtu_pkg::tidx_type                  t_ff, t_in;
   logic [31:0]                        res_ff, res_in;
   logic [31:0]                        rsp_rd_ff, rsp_rd_in;
   logic [mtu_pkg::IRQ_BITS-1:0]       rsp_irq_ff, rsp_irq_in;

   // timer memory
   mtu_pkg::entry_type                 timer_ram [mtu_pkg::NUM_TIMERS];
   logic [mtu_pkg::NUM_TIMERS-1:0]     ram_vld_ff;
   mtu_pkg::entry_type                 ram_q_ff;
   logic                               ram_q_vld_ff;
   logic                               rd_en, wr_en;
   mtu_pkg::tidx_type                  rd_addr, wr_addr;
   mtu_pkg::entry_type                 wr_data;
   mtu_pkg::entry_type                 entry_cur;

   // decode
   logic [3:0]                         req_blk_m1, blk_m1;
   logic                               req_hit, blk_hit, blk_core;
   mtu_pkg::tidx_type                  req_tidx, blk_tidx, t_prev;
   logic [mtu_pkg::IRQ_BITS-1:0]       irq_now;

   mtu_pkg::step_arg_type              step_arg;
   mtu_pkg::step_res_type              step_res;

   mtu_step u_step (
      .arg (step_arg),
      .res (step_res)
   );

   assign req_blk_m1 = req_chan.bus_address[7:4] - 4'd1;
   assign req_hit    = (req_chan.bus_address[7:4] != mtu_pkg::BLK_CORE) &&
                       (req_blk_m1 < NUM_BLKS);
   assign req_tidx   = req_blk_m1[mtu_pkg::TIMER_IDX_BITS-1:0];

   assign blk_m1   = addr_ff[7:4] - 4'd1;
   assign blk_core = (addr_ff[7:4] == mtu_pkg::BLK_CORE);
   assign blk_hit  = !blk_core && (blk_m1 < NUM_BLKS);
   assign blk_tidx = blk_m1[mtu_pkg::TIMER_IDX_BITS-1:0];

   // never-written entries read as zero
   assign entry_cur = ram_q_vld_ff ? ram_q_ff : '0;
   assign t_prev    = t_ff - mtu_pkg::TIMER_IDX_BITS'(1);

   always_comb begin
      step_arg.entry     = entry_cur;
      step_arg.ctl       = ctl_ff[t_ff];
      step_arg.first     = (t_ff == '0);
      step_arg.prev_mark = (t_ff != '0) ? mark_ff[t_prev] : 1'b0;
   end

   always_comb begin
      irq_now = '0;
      for (int i = 0; i < mtu_pkg::IRQ_SHOWN; i++) begin
         irq_now[i] = ctl_ff[i][mtu_pkg::CTL_IP];
      end
   end

   always_comb begin
      state_in     = state_ff;
      presc_cnt_in = presc_cnt_ff;
      presc_rld_in = presc_rld_ff;
      ctl_in       = ctl_ff;
      mark_in      = mark_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      op_in        = op_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      t_in         = t_ff;
      res_in       = res_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_irq_in   = rsp_irq_ff;
      rd_en        = 1'b0;
      rd_addr      = req_tidx;
      wr_en        = 1'b0;
      wr_addr      = t_ff;
      wr_data      = entry_cur;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in   = req_chan.req_type;
               addr_in = req_chan.bus_address;
               data_in = req_chan.write_data;
               res_in  = '0;
               case (req_chan.req_type)
                  mtu_pkg::REQ_TICK: begin
                     if (presc_cnt_ff != '0) begin
                        presc_cnt_in = presc_cnt_ff - mtu_pkg::PRESCALE_BITS'(1);
                        state_in     = S_DONE;
                     end else begin
                        // underflow: reload and walk the timers from 0
                        presc_cnt_in = presc_rld_ff;
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        t_in         = '0;
                        state_in     = S_STEP;
                     end
                  end
                  mtu_pkg::REQ_READ, mtu_pkg::REQ_WRITE: begin
                     rd_en    = req_hit;
                     rd_addr  = req_tidx;
                     state_in = S_BUS;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_BUS: begin
            state_in = S_DONE;
            wr_addr  = blk_tidx;
            if (op_ff == mtu_pkg::REQ_READ) begin
               if (blk_core) begin
                  case (addr_ff[3:0])
                     mtu_pkg::OFS_COUNT:  res_in = 32'(presc_cnt_ff);
                     mtu_pkg::OFS_RELOAD: res_in = 32'(presc_rld_ff);
                     default:             res_in = '0;
                  endcase
               end else if (blk_hit) begin
                  case (addr_ff[3:0])
                     mtu_pkg::OFS_COUNT:  res_in = entry_cur.count;
                     mtu_pkg::OFS_RELOAD: res_in = entry_cur.reload;
                     mtu_pkg::OFS_CTRL:   res_in = 32'(ctl_ff[blk_tidx]);
                     mtu_pkg::OFS_LATCH:  res_in = entry_cur.latch;
                     default:             res_in = '0;
                  endcase
               end
            end else begin
               if (blk_core) begin
                  if (addr_ff[3:0] == mtu_pkg::OFS_RELOAD) begin
                     presc_rld_in = data_ff[mtu_pkg::PRESCALE_BITS-1:0];
                  end
               end else if (blk_hit) begin
                  case (addr_ff[3:0])
                     mtu_pkg::OFS_COUNT: begin
                        wr_en         = 1'b1;
                        wr_data.count = data_ff;
                     end
                     mtu_pkg::OFS_RELOAD: begin
                        wr_en          = 1'b1;
                        wr_data.reload = data_ff;
                     end
                     mtu_pkg::OFS_CTRL: begin
                        ctl_in[blk_tidx] = data_ff[mtu_pkg::CTL_BITS-1:0];
                     end
                     mtu_pkg::OFS_LATCH: begin
                        // data ignored, snapshot the counter
                        wr_en         = 1'b1;
                        wr_data.latch = entry_cur.count;
                     end
                     default: begin
                        wr_en = 1'b0;
                     end
                  endcase
               end
            end
         end

         S_STEP: begin
            // write back timer t while the read of timer t+1 is in flight
            wr_en        = 1'b1;
            wr_addr      = t_ff;
            wr_data      = step_res.entry;
            ctl_in[t_ff] = step_res.ctl;
            if (step_res.set_mark) begin
               mark_in[t_ff] = 1'b1;
            end
            if (step_res.clear_prev_mark && (t_ff != '0)) begin
               mark_in[t_prev] = 1'b0;
            end
            if (t_ff == LAST_TIMER) begin
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = t_ff + mtu_pkg::TIMER_IDX_BITS'(1);
               t_in    = t_ff + mtu_pkg::TIMER_IDX_BITS'(1);
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = res_ff;
               rsp_irq_in   = irq_now;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         presc_cnt_ff <= '0;
         presc_rld_ff <= '0;
         for (int i = 0; i < mtu_pkg::NUM_TIMERS; i++) begin
            ctl_ff[i] <= '0;
         end
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         presc_cnt_ff <= presc_cnt_in;
         presc_rld_ff <= presc_rld_in;
         ctl_ff       <= ctl_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      addr_ff    <= addr_in;
      data_ff    <= data_in;
      t_ff       <= t_in;
      res_ff     <= res_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_irq_ff <= rsp_irq_in;
   end

   // timer memory, one read and one write port, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         timer_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         ram_q_ff <= timer_ram[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_vld_ff   <= '0;
         ram_q_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            ram_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            ram_q_vld_ff <= ram_vld_ff[rd_addr];
         end
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_data   = rsp_rd_ff;
   assign rsp_chan.irq_pending = rsp_irq_ff;

endmodule

[rtl/mtu_step.sv]
// one timer step: pending load, chaining, decrement, underflow handling
// depends on mtu_pkg; combinational, shared by all timers in turn
module mtu_step (
   input  mtu_pkg::step_arg_type arg,
   output mtu_pkg::step_res_type res
);

   logic do_dec;

   always_comb begin
      res                 = '0;
      res.entry           = arg.entry;
      res.ctl             = arg.ctl;
      res.set_mark        = 1'b0;
      res.clear_prev_mark = 1'b0;
      do_dec              = 1'b0;

      if (arg.ctl[mtu_pkg::CTL_EN]) begin
         if (arg.ctl[mtu_pkg::CTL_LD]) begin
            res.entry.count             = arg.entry.reload;
            res.ctl[mtu_pkg::CTL_LD]    = 1'b0;
         end else if (!arg.first && arg.ctl[mtu_pkg::CTL_CH]) begin
            // chained: only moves on the predecessor's underflow
            if (arg.prev_mark) begin
               res.clear_prev_mark = 1'b1;
               do_dec              = 1'b1;
            end
         end else begin
            do_dec = 1'b1;
         end
      end

      if (do_dec) begin
         if (arg.entry.count != 32'd0) begin
            res.entry.count = arg.entry.count - 32'd1;
         end else begin
            res.set_mark = 1'b1;
            if (arg.ctl[mtu_pkg::CTL_RS]) begin
               res.entry.count = arg.entry.reload;
            end else begin
               res.entry.count          = '1;
               res.ctl[mtu_pkg::CTL_EN] = 1'b0;
            end
            if (arg.ctl[mtu_pkg::CTL_IE]) begin
               res.ctl[mtu_pkg::CTL_IP] = 1'b1;
            end
         end
      end
   end

endmodule

[rtl/mtu_chk.sv]
// port-level checks of the multi timer unit, bound to the top level
// depends on mtu_pkg and multi_timer_unit_with_prescaler
module mtu_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [31:0]                  read_data,
   input logic [mtu_pkg::IRQ_BITS-1:0] irq_pending
);

   // one word in flight: taking a word drops ready at once
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another word is in work");

   // a new result shows up exactly when the block turns idle again
   a_result_with_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while the block was busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(irq_pending))
      else $error("stalled result changed or dropped");

endmodule

bind multi_timer_unit_with_prescaler mtu_chk u_mtu_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .read_data   (rsp_chan.read_data),
   .irq_pending (rsp_chan.irq_pending)
);
